// ----- rtl/core/cssv_pkg.sv -----
// Shared types, character codes and message word tables for the sentence validator.
package cssv_pkg;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;

	localparam logic [3:0] FIELD_LIMIT = 4'd12;

	localparam logic [2:0] V_OK       = 3'd0;
	localparam logic [2:0] V_FRAME    = 3'd1;
	localparam logic [2:0] V_CHECKSUM = 3'd2;
	localparam logic [2:0] V_TYPE     = 3'd3;
	localparam logic [2:0] V_FIELDS   = 3'd4;

	localparam logic [2:0] K_NONE = 3'd0;

	// one word per entry, first character in the low byte
	localparam logic [63:0] WORD_TEXT [4] = '{
		64'h0000_004F_4C4C_4548,  // HELLO
		64'h0000_0000_5441_5453,  // STAT
		64'h0000_0000_0044_4D43,  // CMD
		64'h0000_0000_454E_5554   // TUNE
	};
	localparam logic [2:0] WORD_LEN [4]   = '{3'd5, 3'd4, 3'd3, 3'd4};
	localparam logic [3:0] COMMA_NEED [4] = '{4'd2, 4'd12, 4'd4, 4'd9};

	typedef struct packed {
		logic        frame_seen;
		logic [2:0]  after_cnt;
		logic [23:0] tail;
		logic [7:0]  pxor;
		logic [3:0]  comma_cnt;
		logic [3:0]  cand;
		logic [2:0]  wpos;
		logic        wclosed;
	} line_state_t;

	typedef struct packed {
		logic discarding;
		logic line_empty;
	} trk_status_t;

	localparam line_state_t LINE_CLEAR = '{
		frame_seen: 1'b0, after_cnt: 3'd0, tail: 24'd0, pxor: 8'd0,
		comma_cnt: 4'd0, cand: 4'hF, wpos: 3'd0, wclosed: 1'b0
	};

	function automatic logic [7:0] word_char(input logic [1:0] k, input logic [2:0] pos);
		logic [63:0] w;
		w = WORD_TEXT[k];
		return w[{pos, 3'b000} +: 8];
	endfunction

	// {valid, value}
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h41 && c <= 8'h46)
			r = {1'b1, 4'(c - 8'h37)};
		else if (c >= 8'h61 && c <= 8'h66)
			r = {1'b1, 4'(c - 8'h57)};
		return r;
	endfunction

endpackage

// ----- rtl/core/cssv_tracker.sv -----
// Per-line tracking state: framing window, running xor, commas and first-word match.
module cssv_tracker #(
	parameter int LINE_CAPACITY = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [7:0]           rx_byte_s1,
	output logic                 emit,
	output cssv_pkg::line_state_t ls,
	output cssv_pkg::trk_status_t status,
	output logic [31:0]          overflow_total
);
	import cssv_pkg::*;

	localparam int LC_W = $clog2(LINE_CAPACITY);
	localparam logic [LC_W-1:0] LC_MAX = LC_W'(LINE_CAPACITY - 1);

	line_state_t     ls_q, ls_d;
	logic            disc_q, disc_d;
	logic [LC_W-1:0] cnt_q, cnt_d;
	logic [31:0]     ovf_q, ovf_d;
	logic [7:0]      b;

	assign emit = (rx_byte_s1 == CH_LF) && !disc_q && (cnt_q != '0);
	assign ls = ls_q;
	assign status = '{discarding: disc_q, line_empty: (cnt_q == '0)};
	assign overflow_total = ovf_q;

	always_comb begin
		ls_d   = ls_q;
		disc_d = disc_q;
		cnt_d  = cnt_q;
		ovf_d  = ovf_q;
		b      = ls_q.tail[23:16];
		if (fire && rx_byte_s1 != CH_CR) begin
			if (rx_byte_s1 == CH_LF) begin
				disc_d = 1'b0;
				cnt_d  = '0;
				ls_d   = LINE_CLEAR;
			end else if (!disc_q) begin
				if (cnt_q >= LC_MAX) begin
					ovf_d  = ovf_q + 32'd1;
					disc_d = 1'b1;
					cnt_d  = '0;
					ls_d   = LINE_CLEAR;
				end else begin
					cnt_d = cnt_q + 1'b1;
					if (!ls_q.frame_seen) begin
						ls_d.frame_seen = (rx_byte_s1 == CH_DOLLAR);
					end else begin
						if (ls_q.after_cnt >= 3'd3) begin
							ls_d.pxor = ls_q.pxor ^ b;
							if (b == CH_COMMA) begin
								if (ls_q.comma_cnt != 4'd15)
									ls_d.comma_cnt = ls_q.comma_cnt + 4'd1;
								ls_d.wclosed = 1'b1;
							end else if (!ls_q.wclosed) begin
								for (int k = 0; k < 4; k++) begin
									if (ls_q.wpos >= WORD_LEN[k] ||
									    word_char(2'(k), ls_q.wpos) != b)
										ls_d.cand[k] = 1'b0;
								end
								if (ls_q.wpos != 3'd7)
									ls_d.wpos = ls_q.wpos + 3'd1;
							end
						end
						ls_d.tail = {ls_q.tail[15:0], rx_byte_s1};
						if (ls_q.after_cnt < 3'd4)
							ls_d.after_cnt = ls_q.after_cnt + 3'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ls_q   <= LINE_CLEAR;
			disc_q <= 1'b0;
			cnt_q  <= '0;
			ovf_q  <= 32'd0;
		end else begin
			ls_q   <= ls_d;
			disc_q <= disc_d;
			cnt_q  <= cnt_d;
			ovf_q  <= ovf_d;
		end
	end

endmodule

// ----- rtl/core/cssv_judge.sv -----
// Line verdict: frame, checksum, comma limit, message word and exact comma count.
module cssv_judge (
	input  cssv_pkg::line_state_t ls,
	output logic [2:0]            verdict,
	output logic [2:0]            kind
);
	import cssv_pkg::*;

	logic [4:0] hi, lo;
	logic [2:0] found;
	logic [1:0] fidx;

	always_comb begin
		hi    = hex_val(ls.tail[15:8]);
		lo    = hex_val(ls.tail[7:0]);
		found = K_NONE;
		for (int k = 0; k < 4; k++) begin
			if (ls.cand[k] && WORD_LEN[k] == ls.wpos)
				found = 3'(k + 1);
		end
		fidx    = 2'(found - 3'd1);
		verdict = V_OK;
		kind    = K_NONE;
		if (!ls.frame_seen || ls.after_cnt < 3'd4 || ls.tail[23:16] != CH_STAR ||
		    !hi[4] || !lo[4])
			verdict = V_FRAME;
		else if ({hi[3:0], lo[3:0]} != ls.pxor)
			verdict = V_CHECKSUM;
		else if (ls.comma_cnt > FIELD_LIMIT)
			verdict = V_FIELDS;
		else if (found == K_NONE)
			verdict = V_TYPE;
		else if (ls.comma_cnt != COMMA_NEED[fidx])
			verdict = V_FIELDS;
		else
			kind = found;
	end

endmodule

// ----- rtl/core/checksummed_sentence_validator.sv -----
// Top level of the checksummed sentence validator: input register, line tracker, result register.
//
// Input channel: rx_byte with in_valid / in_stall, one received character per request.
// CR is ignored; LF closes a line. A line of the form [junk] '$' payload '*' HH is
// checked: HH (hex, either case) must match the xor of the payload, the first word
// must be HELLO, STAT, CMD or TUNE with its exact comma count.
// Output channel: verdict, message_kind, dropped_lines with out_valid / out_stall,
// one request per non-empty line end. Lines longer than LINE_CAPACITY-1 bytes are
// dropped silently and counted in dropped_lines (wrapping).
// Throughput: one byte per cycle while in_stall is low. A line's result is valid
// once its LF has passed the input register and then the result register.
// A byte in the input register moves on while a result waits, unless it is itself
// an LF with a result; then in_stall rises until the waiting result is taken.
// Reset (arst_n low) clears the line state, the drop counter and both valids.
module checksummed_sentence_validator #(
	parameter int LINE_CAPACITY = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  verdict,
	output logic [2:0]  message_kind,
	output logic [31:0] dropped_lines
);
	import cssv_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        emit, adv;
	line_state_t ls;
	trk_status_t status;
	logic [31:0] ovf;
	logic [2:0]  verdict_c, kind_c;
	logic        out_valid_q;
	logic [2:0]  verdict_q, kind_q;
	logic [31:0] dropped_q;

	assign adv      = valid_s1 && !(emit && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	cssv_tracker #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_tracker (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (adv),
		.rx_byte_s1    (byte_s1),
		.emit          (emit),
		.ls            (ls),
		.status        (status),
		.overflow_total(ovf)
	);

	cssv_judge u_judge (
		.ls     (ls),
		.verdict(verdict_c),
		.kind   (kind_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			verdict_q <= verdict_c;
			kind_q    <= kind_c;
			dropped_q <= ovf;
		end
	end

	assign out_valid     = out_valid_q;
	assign verdict       = verdict_q;
	assign message_kind  = kind_q;
	assign dropped_lines = dropped_q;

	a_kind_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (message_kind == K_NONE || verdict == V_OK))
		else $error("message kind set on a failed line");

	a_verdict_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (verdict <= V_FIELDS))
		else $error("verdict code out of range");

	a_discard_empty: assert property (@(posedge clk) disable iff (!arst_n)
		status.discarding |-> status.line_empty)
		else $error("discarding line still holds bytes");

	a_no_frame_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		!ls.frame_seen |-> (ls.after_cnt == 3'd0 && ls.pxor == 8'd0))
		else $error("payload tracked before start of frame");

	a_emit_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && emit && out_valid_q && out_stall) |-> in_stall)
		else $error("result would overwrite a waiting result");

endmodule
